// ===== hdl/aanorm_pkg.sv =====
// Package for the auto-calibrating axis normalizer.
// Holds the controller state type, the command struct and the fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package aanorm_pkg;

    // The axis number field is three bits wide, so eight axes are addressable.
    localparam int AXIS_W     = 3;
    localparam int AXIS_COUNT = 8;
    localparam int POS_W      = 17;
    localparam int DIV_STEPS  = 17;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam logic [POS_W-1:0] HALF_SCALE = 17'd32768;
    localparam logic [POS_W-1:0] FULL_SCALE = 17'd65536;

    // Item kinds carried in tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RECAL  = 1'b1;

    // Center modes of the configuration register.
    localparam logic MODE_ZERO  = 1'b0;
    localparam logic MODE_FLOAT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } aanorm_state_t;

    typedef struct packed {
        logic load_in;
        logic clear_seen;
        logic update;
        logic setup;
        logic div_step;
        logic out_load;
    } aanorm_cmd_t;

endpackage

// ===== hdl/aanorm_ctrl.sv =====
// Controller state machine of the axis normalizer.
// Sequences one sample through update, setup, division and output load.
// Depends on aanorm_pkg.
`timescale 1ns / 1ps

module aanorm_ctrl
    import aanorm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_op,
    input  logic        m_tready,
    output logic        s_tready,
    output logic        m_tvalid,
    output aanorm_cmd_t cmd
);

    aanorm_state_t            state_reg;
    aanorm_state_t            state_next;
    logic [STEP_CNT_W-1:0]    count_reg;
    logic [STEP_CNT_W-1:0]    count_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic                     in_xfer;
    logic                     slot_free;
    logic                     last_step;

    assign in_xfer   = s_tvalid && (state_reg == ST_IDLE);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign last_step = (count_reg == STEP_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_op == OP_SAMPLE))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        count_next     = count_reg;
        cmd.load_in    = in_xfer && (s_op == OP_SAMPLE);
        cmd.clear_seen = in_xfer && (s_op == OP_RECAL);
        unique case (state_reg)
            ST_IDLE:   ;
            ST_UPDATE: cmd.update = 1'b1;
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                count_next = '0;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
            end
            ST_FINISH: cmd.out_load = slot_free;
            default:   ;
        endcase
        m_tvalid_next = cmd.out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hdl/aanorm_dp.sv =====
// Datapath of the axis normalizer: per-axis min/max store, operand setup,
// serial restoring divider and the output register. Depends on aanorm_pkg.
`timescale 1ns / 1ps

module aanorm_dp
    import aanorm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  aanorm_cmd_t                   cmd,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic [AXIS_W-1:0]             in_axis,
    input  logic signed [SAMPLE_BITS-1:0] in_raw,
    output logic [AXIS_W-1:0]             out_axis,
    output logic [POS_W-1:0]              out_position,
    output logic signed [SAMPLE_BITS-1:0] out_low,
    output logic signed [SAMPLE_BITS-1:0] out_high
);

    localparam int NUM_W = SAMPLE_BITS + POS_W;

    logic                          centering_reg;
    logic [AXIS_COUNT-1:0]         seen_reg;
    logic signed [SAMPLE_BITS-1:0] lo_mem [AXIS_COUNT];
    logic signed [SAMPLE_BITS-1:0] hi_mem [AXIS_COUNT];

    logic [AXIS_W-1:0]             axis_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0]        divisor_reg;
    logic [SAMPLE_BITS-1:0]        rem_reg;
    logic [POS_W-1:0]              num_lo_reg;
    logic [POS_W-1:0]              quo_reg;
    logic                          force_zero_reg;
    logic                          negative_reg;

    logic [AXIS_W-1:0]             out_axis_reg;
    logic [POS_W-1:0]              out_pos_reg;
    logic signed [SAMPLE_BITS-1:0] out_lo_reg;
    logic signed [SAMPLE_BITS-1:0] out_hi_reg;

    logic signed [SAMPLE_BITS-1:0] cur_lo;
    logic signed [SAMPLE_BITS-1:0] cur_hi;
    logic signed [SAMPLE_BITS-1:0] lo_next;
    logic signed [SAMPLE_BITS-1:0] hi_next;

    logic                          neg;
    logic [SAMPLE_BITS-1:0]        mag_v;
    logic [SAMPLE_BITS-1:0]        mag_lo;
    logic [SAMPLE_BITS-1:0]        span;
    logic [SAMPLE_BITS-1:0]        divisor_next;
    logic                          force_zero_next;
    logic [NUM_W-1:0]              num_wide;

    logic [SAMPLE_BITS:0]          trial;
    logic [SAMPLE_BITS:0]          diff;
    logic                          ge;

    logic [POS_W-1:0]              quo_eff;
    logic [POS_W-1:0]              pos_next;

    // Min/max update: a fresh axis takes the sample as both bounds.
    always_comb
    begin
        cur_lo = lo_mem[axis_reg];
        cur_hi = hi_mem[axis_reg];
        if (!seen_reg[axis_reg])
        begin
            lo_next = sample_reg;
            hi_next = sample_reg;
        end
        else
        begin
            lo_next = (sample_reg < cur_lo) ? sample_reg : cur_lo;
            hi_next = (sample_reg > cur_hi) ? sample_reg : cur_hi;
        end
    end

    // Operand setup for the divider and the cases that force a zero quotient.
    always_comb
    begin
        neg    = sample_reg[SAMPLE_BITS-1];
        mag_v  = neg ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(sample_reg)) : SAMPLE_BITS'(sample_reg);
        mag_lo = lo_reg[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(lo_reg))
                                       : SAMPLE_BITS'(lo_reg);
        span   = SAMPLE_BITS'(hi_reg) - SAMPLE_BITS'(lo_reg);
        if (centering_reg == MODE_ZERO)
        begin
            divisor_next    = neg ? mag_lo : SAMPLE_BITS'(hi_reg);
            force_zero_next = (sample_reg == '0);
            num_wide        = {2'b00, mag_v, 15'd0};
        end
        else
        begin
            divisor_next    = span;
            force_zero_next = (span == '0) || (span < mag_v) || neg;
            num_wide        = {1'b0, mag_v, 16'd0};
        end
    end

    // One quotient bit per step of the restoring divider.
    always_comb
    begin
        trial = {rem_reg, num_lo_reg[POS_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        ge    = (trial >= {1'b0, divisor_reg});
    end

    always_comb
    begin
        quo_eff = force_zero_reg ? '0 : quo_reg;
        if (centering_reg == MODE_ZERO)
        begin
            pos_next = negative_reg ? (HALF_SCALE - quo_eff) : (HALF_SCALE + quo_eff);
        end
        else
        begin
            pos_next = quo_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centering_reg <= MODE_ZERO;
            seen_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                centering_reg <= cfg_wdata;
            end
            if (cmd.clear_seen)
            begin
                seen_reg <= '0;
            end
            else if (cmd.update)
            begin
                seen_reg[axis_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            axis_reg   <= in_axis;
            sample_reg <= in_raw;
        end
        if (cmd.update)
        begin
            lo_mem[axis_reg] <= lo_next;
            hi_mem[axis_reg] <= hi_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
        end
        if (cmd.setup)
        begin
            divisor_reg    <= divisor_next;
            force_zero_reg <= force_zero_next;
            negative_reg   <= neg;
            rem_reg        <= num_wide[NUM_W-1:POS_W];
            num_lo_reg     <= num_wide[POS_W-1:0];
            quo_reg        <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg    <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            num_lo_reg <= {num_lo_reg[POS_W-2:0], 1'b0};
            quo_reg    <= {quo_reg[POS_W-2:0], ge};
        end
        if (cmd.out_load)
        begin
            out_axis_reg <= axis_reg;
            out_pos_reg  <= pos_next;
            out_lo_reg   <= lo_reg;
            out_hi_reg   <= hi_reg;
        end
    end

    assign out_axis     = out_axis_reg;
    assign out_position = out_pos_reg;
    assign out_low      = out_lo_reg;
    assign out_high     = out_hi_reg;

endmodule

// ===== hdl/axis_autocal_normalizer_top.sv =====
// Top level of the auto-calibrating axis normalizer.
// Instantiates aanorm_ctrl and aanorm_dp; depends on aanorm_pkg.
`timescale 1ns / 1ps

// This block turns raw signed joystick axis samples into normalized unsigned
// positions, where 65536 stands for 1.0, while learning each axis's range on
// the fly. Each input transfer is either a sample (tuser low) for one of eight
// axes or a recalibrate command (tuser high) that forgets every learned range.
// A sample first widens its axis's running minimum and maximum, then produces
// one output transfer with the axis, the position and the updated bounds. In
// zero-centered mode zero maps to one half and each side scales against its
// own bound; in floating-center mode the sample is divided by the max-min span,
// and spans of zero, samples beyond the span and negative samples give zero.
// From its input transfer a sample passes through acceptance, an update of the
// min/max store, the operand setup, the bit-serial restoring divider and the
// output register load, which waits for a free output slot, before the block
// is ready again. A recalibrate leaves it ready. The output register lets the
// next sample enter while a result still waits downstream. The user must write
// the centering mode register (cfg_we/cfg_wdata) only while idle; not enforced.

module axis_autocal_normalizer_top
    import aanorm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0 up: axis_index (3), raw_value (SAMPLE_BITS), zero fill.
    input  logic [((AXIS_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // Fields from bit 0 up: op (1).
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0 up: axis_out (3), position (17), span_low (SAMPLE_BITS),
    // span_high (SAMPLE_BITS), zero fill.
    output logic [((AXIS_W + POS_W + 2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IN_W        = AXIS_W + SAMPLE_BITS;
    localparam int OUT_W       = AXIS_W + POS_W + 2 * SAMPLE_BITS;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int POS_LSB     = AXIS_W;
    localparam int LO_LSB      = AXIS_W + POS_W;
    localparam int HI_LSB      = LO_LSB + SAMPLE_BITS;

    aanorm_cmd_t                   cmd;
    logic [AXIS_W-1:0]             out_axis;
    logic [POS_W-1:0]              out_position;
    logic signed [SAMPLE_BITS-1:0] out_low;
    logic signed [SAMPLE_BITS-1:0] out_high;

    // The controller sees only the handshake and the item kind.
    aanorm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    aanorm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_axis      (s_tdata[AXIS_W-1:0]),
        .in_raw       (s_tdata[IN_W-1:AXIS_W]),
        .out_axis     (out_axis),
        .out_position (out_position),
        .out_low      (out_low),
        .out_high     (out_high)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = OUT_TDATA_W'({out_high, out_low, out_position, out_axis});

    // A delivered position never exceeds full scale.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[LO_LSB-1:POS_LSB] <= FULL_SCALE))
        else $error("position above full scale");

    // The reported bounds of an axis are always ordered.
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[HI_LSB-1:LO_LSB]) <=
                      $signed(m_tdata[HI_LSB+SAMPLE_BITS-1:HI_LSB])))
        else $error("span_low above span_high");

    // A recalibrate transfer is finished in its own cycle.
    a_recal_single: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_RECAL)) |=> s_tready)
        else $error("recalibrate stalled the input");

    // A sample transfer occupies the block, so no second one follows at once.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_SAMPLE)) |=> !s_tready)
        else $error("input ready right after a sample transfer");

endmodule

// ===== sim/axis_autocal_normalizer_top_test.sv =====
// Self-checking testbench for axis_autocal_normalizer_top.
// Holds a scoreboard class with its own min/max position predictor and
// the tasks and process that drive both stream ports; depends on aanorm_pkg and the RTL.
`timescale 1ns / 1ps

module axis_autocal_normalizer_top_test;
    import aanorm_pkg::*;

    localparam int SAMPLE_W      = 16;
    localparam int IN_W          = ((AXIS_W + SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W         = ((AXIS_W + POS_W + 2 * SAMPLE_W + 7) / 8) * 8;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 6;
    // Well beyond what a sample needs, so a trailing recalibrate
    // has surely retired before the mode register is touched.
    localparam int DRAIN_CYCLES  = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 271;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_RUNS
    } ready_style_t;

    typedef struct {
        logic [AXIS_W-1:0]          axis;
        logic [POS_W-1:0]           position;
        logic signed [SAMPLE_W-1:0] span_low;
        logic signed [SAMPLE_W-1:0] span_high;
    } norm_result_t;

    // Tracks the learned range of every axis and the positions still owed
    // by the block, in the order they must come out.
    class position_board;
        longint       lowest [AXIS_COUNT];
        longint       highest [AXIS_COUNT];
        bit           seen [AXIS_COUNT];
        logic         center = MODE_ZERO;
        norm_result_t pending_positions[$];
        int unsigned  fault_count = 0;
        int unsigned  samples = 0;
        int unsigned  recals = 0;
        int unsigned  checked = 0;

        function int pending();
            return pending_positions.size();
        endfunction

        function void note_input(logic op, logic [AXIS_W-1:0] axis,
                                 logic signed [SAMPLE_W-1:0] raw);
            norm_result_t r;
            longint v;
            longint mag_v;
            longint span;
            longint pos;
            longint half;
            longint full;
            half = HALF_SCALE;
            full = FULL_SCALE;
            if (op == OP_RECAL)
            begin
                foreach (seen[i])
                    seen[i] = 1'b0;
                recals++;
                return;
            end
            v = raw;
            // The first sample after a recalibrate defines the whole range.
            if (!seen[axis])
            begin
                lowest[axis]  = v;
                highest[axis] = v;
                seen[axis]    = 1'b1;
            end
            else
            begin
                if (v < lowest[axis])
                    lowest[axis] = v;
                if (v > highest[axis])
                    highest[axis] = v;
            end
            mag_v = (v < 0) ? -v : v;
            if (center == MODE_ZERO)
            begin
                if (v == 0)
                    pos = half;
                else if (v < 0)
                    pos = half - (mag_v * half) / (-lowest[axis]);
                else
                    pos = half + (v * half) / highest[axis];
            end
            else
            begin
                span = highest[axis] - lowest[axis];
                if (span == 0 || span < mag_v || v < 0)
                    pos = 0;
                else
                    pos = (v * full) / span;
            end
            r.axis      = axis;
            r.position  = pos[POS_W-1:0];
            r.span_low  = lowest[axis][SAMPLE_W-1:0];
            r.span_high = highest[axis][SAMPLE_W-1:0];
            pending_positions.push_back(r);
            samples++;
        endfunction

        function void compare_field(string field, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                fault_count++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] word);
            norm_result_t want;
            if (pending_positions.size() == 0)
            begin
                $display("%0t: output transfer with nothing expected, expected none, actual %h",
                         $time, word);
                fault_count++;
                return;
            end
            want = pending_positions.pop_front();
            compare_field("axis_out", want.axis, word[AXIS_W-1:0]);
            compare_field("position", want.position, word[AXIS_W +: POS_W]);
            compare_field("span_low", want.span_low,
                          $signed(word[AXIS_W + POS_W +: SAMPLE_W]));
            compare_field("span_high", want.span_high,
                          $signed(word[AXIS_W + POS_W + SAMPLE_W +: SAMPLE_W]));
            checked++;
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    position_board board;
    ready_style_t  ready_style = READY_ALWAYS;
    bit            gaps_on = 1'b1;
    int unsigned   burst_left = 0;
    int unsigned   hold_off_cycles = 0;
    int unsigned   holds_done = 0;
    int unsigned   mode_writes = 0;
    int unsigned   cycle_count = 0;

    axis_autocal_normalizer_top #(
        .SAMPLE_BITS(SAMPLE_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d positions outstanding.",
                     cycle_count, board.pending());
            $display("FAIL axis_autocal_normalizer_top");
            $finish;
        end
    end

    // Every output transfer is checked against the oldest owed position.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // Output side: one of three stall patterns, or a long hold-off on request
    // so the block backs up and stops taking input transfers.
    initial
    begin : ready_pattern
        int unsigned run_left;
        logic level;
        run_left = 0;
        level = 1'b1;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                holds_done++;
            end
            else
            begin
                case (ready_style)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_COIN:   m_tready <= ($urandom_range(0, 9) < 7);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            level = ~level;
                            run_left = level ? $urandom_range(1, 6) : $urandom_range(1, 10);
                        end
                        run_left--;
                        m_tready <= level;
                    end
                endcase
            end
        end
    end

    // Offers one item and returns at the edge of its transfer with tvalid
    // still high. Bursts of random length are separated by random gaps when gaps_on is set.
    task automatic send_item(input logic op, input logic [AXIS_W-1:0] axis,
                             input logic signed [SAMPLE_W-1:0] raw);
        logic [IN_W-1:0] word;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        word = '0;
        word[AXIS_W-1:0] = axis;
        word[AXIS_W +: SAMPLE_W] = raw;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(op, axis, raw);
    endtask

    // Stops offering and waits until every owed position has come out,
    // plus a margin for a recalibrate that gives no output.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.center = mode;
        mode_writes++;
    endtask

    // Mixes zero, both extremes, small values around zero and full-range
    // values, so ranges grow slowly and the span corner cases come up often.
    function automatic logic signed [SAMPLE_W-1:0] draw_reading();
        int small_val;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3:
            begin
                small_val = int'($urandom_range(0, 512)) - 256;
                return small_val[SAMPLE_W-1:0];
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int phase;
        int n;
        board = new;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_SAMPLE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Zero-centered: zero, both extremes, a half-way negative value,
        // a first sample that is negative, and a recalibrate that restarts
        // an axis's range.
        write_mode(MODE_ZERO);
        send_item(OP_RECAL, 3'd7, 16'shFFFF);
        send_item(OP_SAMPLE, 3'd0, 16'sh0000);
        send_item(OP_SAMPLE, 3'd0, 16'sh8000);
        send_item(OP_SAMPLE, 3'd0, 16'sh7FFF);
        send_item(OP_SAMPLE, 3'd0, -16'sd16384);
        send_item(OP_SAMPLE, 3'd0, 16'sd1);
        send_item(OP_SAMPLE, 3'd7, -16'sd1);
        send_item(OP_SAMPLE, 3'd7, 16'sd5);
        send_item(OP_RECAL, 3'd0, 16'sh0000);
        send_item(OP_SAMPLE, 3'd0, 16'sd100);

        // Floating center: zero span, a sample beyond the span, a negative
        // sample, a sample equal to the span and the full 16-bit span.
        write_mode(MODE_FLOAT);
        send_item(OP_SAMPLE, 3'd3, 16'sd100);
        send_item(OP_SAMPLE, 3'd3, 16'sd200);
        send_item(OP_SAMPLE, 3'd3, 16'sd50);
        send_item(OP_SAMPLE, 3'd3, -16'sd20);
        send_item(OP_SAMPLE, 3'd3, 16'sd0);
        send_item(OP_SAMPLE, 3'd5, 16'sd0);
        send_item(OP_SAMPLE, 3'd5, 16'sh7FFF);
        send_item(OP_SAMPLE, 3'd5, 16'sh8000);
        send_item(OP_SAMPLE, 3'd5, 16'sh7FFF);
        send_item(OP_SAMPLE, 3'd2, 16'sh8000);
        send_item(OP_RECAL, 3'd5, 16'sh7FFF);
        send_item(OP_SAMPLE, 3'd5, 16'sd7);

        // Random phases alternate the mode and change how both sides idle.
        // Phase 3 runs with no idling at all; phases 1 and 4 start with a
        // long output hold-off while input transfers keep being offered.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_mode((phase % 2 == 0) ? MODE_ZERO : MODE_FLOAT);
            ready_style = ready_style_t'(phase % 3);
            gaps_on = (phase != 3);
            if (phase == 1 || phase == 4)
                hold_off_cycles = HOLD_CYCLES;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 4)
                    send_item(OP_RECAL, AXIS_W'($urandom), SAMPLE_W'($urandom));
                else
                    send_item(OP_SAMPLE, AXIS_W'($urandom_range(0, AXIS_COUNT - 1)),
                              draw_reading());
            end
        end

        settle();
        $display("Run covered %0d samples and %0d recalibrations over %0d center mode writes.",
                 board.samples, board.recals, mode_writes);
        $display("%0d positions checked, %0d long output hold-offs, %0d mismatches.",
                 board.checked, holds_done, board.fault_count);
        if (board.fault_count == 0 && board.pending() == 0)
            $display("PASS axis_autocal_normalizer_top");
        else
            $display("FAIL axis_autocal_normalizer_top");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/aanorm_pkg.sv
hdl/aanorm_ctrl.sv
hdl/aanorm_dp.sv
hdl/axis_autocal_normalizer_top.sv
sim/axis_autocal_normalizer_top_test.sv
